@@ rtl/core/assert_macros.svh @@
// Assertion macros for the set difference RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ESD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ESD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ rtl/core/esd_pkg.sv @@
// Types and constants of the epoch-stamped set difference block.
package esd_pkg;

    // Sizing of the stores and counters.
    localparam int NUM_SAMPLES = 1024;
    localparam int MAX_DEST    = 1024;
    localparam int MAX_SOURCE  = 4096;
    localparam int EPOCH_BITS  = 16;

    localparam int SAMPLE_AW = $clog2(NUM_SAMPLES);
    localparam int DEST_AW   = $clog2(MAX_DEST);
    localparam int DEST_CW   = $clog2(MAX_DEST + 1);
    localparam int SRC_CW    = $clog2(MAX_SOURCE);

    // Fixed field widths of the transactions.
    localparam int OP_W      = 2;
    localparam int SAMPLE_W  = 10;
    localparam int FEATURE_W = 16;
    localparam int POS_W     = 12;

    localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = {EPOCH_BITS{1'b1}};

    // Operation codes.
    localparam logic [OP_W-1:0] OP_BEGIN_ROUND   = 2'd0;
    localparam logic [OP_W-1:0] OP_REGISTER_DEST = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY_SOURCE  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [SAMPLE_W-1:0]  sample;
        logic [FEATURE_W-1:0] feature;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] missing_sample;
        logic [POS_W-1:0]    source_position;
    } out_item_t;

    // One word of the per-sample store.
    typedef struct packed {
        logic [EPOCH_BITS-1:0] stamp;
        logic [DEST_AW-1:0]    run_start;
        logic [DEST_CW-1:0]    run_length;
    } samp_entry_t;

    typedef struct packed {
        logic                 we;
        logic [SAMPLE_AW-1:0] waddr;
        samp_entry_t          wdata;
        logic                 re;
        logic [SAMPLE_AW-1:0] raddr;
    } samp_req_t;

    typedef struct packed {
        logic                 we;
        logic [DEST_AW-1:0]   waddr;
        logic [FEATURE_W-1:0] wdata;
        logic                 re;
        logic [DEST_AW-1:0]   raddr;
    } feat_req_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } emit_t;

endpackage

@@ rtl/core/esd_ram.sv @@
// Generic simple dual-port RAM with registered read.
module esd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/esd_ctrl.sv @@
// Sequencer of the set difference block: stamp lookup, run scan, clear sweep.
`include "assert_macros.svh"

module esd_ctrl import esd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_payload,
    input  logic                 match_features,
    input  logic                 out_free,
    output emit_t                emit,
    output samp_req_t            samp_req,
    input  samp_entry_t          samp_rd_data,
    output feat_req_t            feat_req,
    input  logic [FEATURE_W-1:0] feat_rd_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                state_reg,     state_next;
    logic [EPOCH_BITS-1:0] epoch_reg,     epoch_next;
    logic [DEST_CW-1:0]    dest_count_reg, dest_count_next;
    logic [SRC_CW-1:0]     src_count_reg, src_count_next;
    logic [SAMPLE_AW-1:0]  clr_addr_reg,  clr_addr_next;
    logic                  pending_reg,   pending_next;
    in_item_t              item_reg,      item_next;
    logic [SRC_CW-1:0]     pos_reg,       pos_next;
    logic [DEST_CW-1:0]    scan_idx_reg,  scan_idx_next;
    logic [DEST_CW-1:0]    remain_reg,    remain_next;

    logic sample_ok;
    logic hit;
    logic can_issue;
    logic wrap_start;
    logic wrap_armed;

    assign sample_ok = (32'(s_payload.sample) < NUM_SAMPLES);
    // Single compare unit: one destination feature a cycle.
    assign hit       = pending_reg && (feat_rd_data == item_reg.feature);
    assign can_issue = (remain_reg != '0) && (scan_idx_reg < dest_count_reg);

    assign wrap_start = (state_reg == ST_IDLE) && s_valid
                        && (s_payload.operation == OP_BEGIN_ROUND)
                        && (epoch_reg == EPOCH_MAX);
    assign wrap_armed = (state_reg == ST_CLEAR) && (epoch_reg == EPOCH_BITS'(1));

    always_comb begin
        state_next      = state_reg;
        epoch_next      = epoch_reg;
        dest_count_next = dest_count_reg;
        src_count_next  = src_count_reg;
        clr_addr_next   = clr_addr_reg;
        pending_next    = pending_reg;
        item_next       = item_reg;
        pos_next        = pos_reg;
        scan_idx_next   = scan_idx_reg;
        remain_next     = remain_reg;
        s_ready         = 1'b0;
        samp_req        = '0;
        feat_req        = '0;
        emit            = '0;

        case (state_reg)
            ST_CLEAR: begin
                samp_req.we    = 1'b1;
                samp_req.waddr = clr_addr_reg;
                samp_req.wdata = '0;
                clr_addr_next  = clr_addr_reg + SAMPLE_AW'(1);
                if (clr_addr_reg == SAMPLE_AW'(NUM_SAMPLES - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                s_ready        = 1'b1;
                samp_req.re    = s_valid;
                samp_req.raddr = SAMPLE_AW'(s_payload.sample);
                if (s_valid) begin
                    item_next = s_payload;
                    case (s_payload.operation)
                        OP_BEGIN_ROUND: begin
                            dest_count_next = '0;
                            src_count_next  = '0;
                            if (epoch_reg == EPOCH_MAX) begin
                                epoch_next    = EPOCH_BITS'(1);
                                clr_addr_next = '0;
                                state_next    = ST_CLEAR;
                            end else begin
                                epoch_next = epoch_reg + EPOCH_BITS'(1);
                            end
                        end
                        OP_REGISTER_DEST: begin
                            if (sample_ok && (dest_count_reg < DEST_CW'(MAX_DEST))) begin
                                state_next = ST_LOOKUP;
                            end
                        end
                        OP_QUERY_SOURCE: begin
                            pos_next = src_count_reg;
                            if (src_count_reg < SRC_CW'(MAX_SOURCE - 1)) begin
                                src_count_next = src_count_reg + SRC_CW'(1);
                            end
                            state_next = sample_ok ? ST_LOOKUP : ST_EMIT;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_LOOKUP: begin
                if (item_reg.operation == OP_REGISTER_DEST) begin
                    samp_req.we    = 1'b1;
                    samp_req.waddr = SAMPLE_AW'(item_reg.sample);
                    if (samp_rd_data.stamp != epoch_reg) begin
                        samp_req.wdata.stamp      = epoch_reg;
                        samp_req.wdata.run_start  = DEST_AW'(dest_count_reg);
                        samp_req.wdata.run_length = DEST_CW'(1);
                    end else begin
                        samp_req.wdata.stamp      = samp_rd_data.stamp;
                        samp_req.wdata.run_start  = samp_rd_data.run_start;
                        samp_req.wdata.run_length = samp_rd_data.run_length + DEST_CW'(1);
                    end
                    feat_req.we     = 1'b1;
                    feat_req.waddr  = DEST_AW'(dest_count_reg);
                    feat_req.wdata  = item_reg.feature;
                    dest_count_next = dest_count_reg + DEST_CW'(1);
                    state_next      = ST_IDLE;
                end else if (samp_rd_data.stamp != epoch_reg) begin
                    state_next = ST_EMIT;
                end else if (!match_features) begin
                    state_next = ST_IDLE;
                end else begin
                    scan_idx_next = DEST_CW'(samp_rd_data.run_start);
                    remain_next   = samp_rd_data.run_length;
                    pending_next  = 1'b0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN: begin
                if (hit) begin
                    pending_next = 1'b0;
                    state_next   = ST_IDLE;
                end else if (can_issue) begin
                    feat_req.re   = 1'b1;
                    feat_req.raddr = DEST_AW'(scan_idx_reg);
                    scan_idx_next = scan_idx_reg + DEST_CW'(1);
                    remain_next   = remain_reg - DEST_CW'(1);
                    pending_next  = 1'b1;
                end else begin
                    pending_next = 1'b0;
                    state_next   = ST_EMIT;
                end
            end

            ST_EMIT: begin
                emit.valid                = 1'b1;
                emit.item.missing_sample  = item_reg.sample;
                emit.item.source_position = POS_W'(pos_reg);
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            epoch_reg      <= '0;
            dest_count_reg <= '0;
            src_count_reg  <= '0;
            clr_addr_reg   <= '0;
            pending_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            epoch_reg      <= epoch_next;
            dest_count_reg <= dest_count_next;
            src_count_reg  <= src_count_next;
            clr_addr_reg   <= clr_addr_next;
            pending_reg    <= pending_next;
        end
        item_reg     <= item_next;
        pos_reg      <= pos_next;
        scan_idx_reg <= scan_idx_next;
        remain_reg   <= remain_next;
    end

    `ESD_ASSERT_IMP(a_feat_rw_excl, aclk, aresetn, feat_req.re, !feat_req.we)
    `ESD_ASSERT_IMP(a_scan_in_list, aclk, aresetn, feat_req.re, 32'(feat_req.raddr) < 32'(dest_count_reg))
    `ESD_ASSERT_IMP(a_src_sat, aclk, aresetn, 1'b1, src_count_reg <= SRC_CW'(MAX_SOURCE - 1))
    `ESD_ASSERT_NEXT(a_wrap_clears, aclk, aresetn, wrap_start, wrap_armed)

endmodule

@@ rtl/core/epoch_stamped_set_difference.sv @@
// Top level of the epoch-stamped set difference block.
//
// Reports, per round, the source entries whose sample is missing from the
// destination list or, in feature mode, whose feature is not in the sample's
// run. A begin-round transaction advances the epoch; when the epoch wraps,
// the stamp store is swept to zero, one sample a cycle, which holds s_ready
// low for the whole sweep. The same sweep runs after reset, so the block
// first accepts a transaction once it ends. A destination transaction reads
// the per-sample store, then writes stamp, run and feature. A source
// transaction reads the per-sample store; the stamp alone decides unless it
// is current in feature mode, where the single feature compare walks the run
// one entry per cycle, stopping at the first match and producing a result
// when none matches. A result that finds the output register still full
// waits for it to drain. A finished result sits in the output register
// while the next transaction is accepted.
// Writes to match_features land on any cycle with cfg_wr_en high; issue them
// only while the block is idle.
module epoch_stamped_set_difference import esd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    logic        match_features_reg;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_payload_reg;
    logic        out_free;
    emit_t       emit;
    samp_req_t   samp_req;
    samp_entry_t samp_rd_data;
    feat_req_t   feat_req;
    logic [FEATURE_W-1:0] feat_rd_data;
    logic [$bits(samp_entry_t)-1:0] samp_rd_bits;

    // Output slot is free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = emit.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_features_reg <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                match_features_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
        // Load the result only when the slot frees up; hold it otherwise.
        if (emit.valid && out_free) begin
            m_payload_reg <= emit.item;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Sequencer: owns the epoch, the list counters and the clear sweep.
    esd_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .match_features (match_features_reg),
        .out_free       (out_free),
        .emit           (emit),
        .samp_req       (samp_req),
        .samp_rd_data   (samp_rd_data),
        .feat_req       (feat_req),
        .feat_rd_data   (feat_rd_data)
    );

    // Per-sample store: stamp, run start and run length in one word.
    esd_ram #(
        .WIDTH ($bits(samp_entry_t)),
        .DEPTH (NUM_SAMPLES)
    ) u_samp_ram (
        .aclk  (aclk),
        .we    (samp_req.we),
        .waddr (samp_req.waddr),
        .wdata (samp_req.wdata),
        .re    (samp_req.re),
        .raddr (samp_req.raddr),
        .rdata (samp_rd_bits)
    );

    assign samp_rd_data = samp_entry_t'(samp_rd_bits);

    // Destination features in list order.
    esd_ram #(
        .WIDTH (FEATURE_W),
        .DEPTH (MAX_DEST)
    ) u_feat_ram (
        .aclk  (aclk),
        .we    (feat_req.we),
        .waddr (feat_req.waddr),
        .wdata (feat_req.wdata),
        .re    (feat_req.re),
        .raddr (feat_req.raddr),
        .rdata (feat_rd_data)
    );

endmodule

@@ bench/epoch_stamped_set_difference_test.sv @@
// Self-checking bench for the epoch-stamped set difference block.
`timescale 1ns / 100ps

module epoch_stamped_set_difference_test;
    import esd_pkg::*;

    // Operation code 3 has no meaning; the block must drop it silently.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int    HALF_PERIOD   = 6;
    localparam int    RESET_CYCLES  = 10;
    // Longest stretch with no result: a full stamp sweep or a long run scan.
    localparam int    SETTLE_CYCLES = 1200;
    localparam int    DRAIN_LIMIT   = 20000;
    localparam int    FEATURE_TOP   = (1 << FEATURE_W) - 1;
    localparam longint TIMEOUT_NS   = 2_000_000;

    // Tracks which source entries must come back as missing, in order.
    class missing_entry_scoreboard;
        bit [EPOCH_BITS-1:0] stamp_of [NUM_SAMPLES];
        bit [EPOCH_BITS-1:0] epoch;
        bit [DEST_AW-1:0]    run_first [NUM_SAMPLES];
        bit [DEST_CW-1:0]    run_len [NUM_SAMPLES];
        bit [FEATURE_W-1:0]  dest_feature [MAX_DEST];
        bit [DEST_CW-1:0]    dest_fill;
        bit [SRC_CW-1:0]     source_next;
        bit                  feature_mode;
        out_item_t           awaited_missing [$];
        int unsigned         failures;

        function bit run_has_feature(logic [SAMPLE_W-1:0] smp, logic [FEATURE_W-1:0] feat);
            int j;
            for (int k = 0; k < int'(run_len[smp]); k++) begin
                j = int'(run_first[smp]) + k;
                if (j >= int'(dest_fill) || j >= MAX_DEST) break;
                if (dest_feature[j[DEST_AW-1:0]] == feat) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_input(in_item_t t);
            out_item_t         miss;
            bit [SRC_CW-1:0]   pos;
            bit                missing;
            case (t.operation)
                OP_BEGIN_ROUND: begin
                    // Roll over: clear every stamp, then restart the count at one.
                    if (epoch == EPOCH_MAX) begin
                        epoch = '0;
                        foreach (stamp_of[i]) stamp_of[i] = '0;
                    end
                    epoch       = epoch + 1'b1;
                    dest_fill   = '0;
                    source_next = '0;
                end
                OP_REGISTER_DEST: begin
                    if (int'(t.sample) < NUM_SAMPLES && int'(dest_fill) < MAX_DEST) begin
                        if (stamp_of[t.sample] != epoch) begin
                            stamp_of[t.sample]  = epoch;
                            run_first[t.sample] = dest_fill[DEST_AW-1:0];
                            run_len[t.sample]   = DEST_CW'(1);
                        end else begin
                            run_len[t.sample] = run_len[t.sample] + 1'b1;
                        end
                        dest_feature[dest_fill[DEST_AW-1:0]] = t.feature;
                        dest_fill = dest_fill + 1'b1;
                    end
                end
                OP_QUERY_SOURCE: begin
                    pos = source_next;
                    if (int'(source_next) < MAX_SOURCE - 1) source_next = source_next + 1'b1;
                    if (int'(t.sample) >= NUM_SAMPLES)
                        missing = 1'b1;
                    else if (stamp_of[t.sample] != epoch)
                        missing = 1'b1;
                    else if (feature_mode)
                        missing = !run_has_feature(t.sample, t.feature);
                    else
                        missing = 1'b0;
                    if (missing) begin
                        miss.missing_sample  = t.sample;
                        miss.source_position = pos;
                        awaited_missing.push_back(miss);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (awaited_missing.size() == 0) begin
                $error("unexpected result: missing_sample %0d source_position %0d",
                       got.missing_sample, got.source_position);
                failures++;
                return;
            end
            want = awaited_missing.pop_front();
            if (got.missing_sample !== want.missing_sample) begin
                $error("missing_sample: expected %0d, got %0d",
                       want.missing_sample, got.missing_sample);
                failures++;
            end
            if (got.source_position !== want.source_position) begin
                $error("source_position: expected %0d, got %0d",
                       want.source_position, got.source_position);
                failures++;
            end
        endfunction

        function void report_leftovers();
            if (awaited_missing.size() != 0) begin
                $error("%0d expected results never arrived, oldest missing_sample %0d",
                       awaited_missing.size(), awaited_missing[0].missing_sample);
                failures += awaited_missing.size();
                awaited_missing.delete();
            end
        endfunction
    endclass

    logic      aclk        = 1'b0;
    logic      aresetn     = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    logic      cfg_wr_data = 1'b0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    in_item_t  s_payload   = '0;
    logic      m_valid;
    logic      m_ready     = 1'b0;
    out_item_t m_payload;

    missing_entry_scoreboard sb = new();

    // Idle odds per cycle, in percent, for each side of the block.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    // Transactions the block acts on; unused op codes are left out.
    int unsigned items_sent = 0;

    epoch_stamped_set_difference dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Hard stop in case the block hangs or a result never shows up.
    initial begin
        #TIMEOUT_NS;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: check what was handed over at this edge, then pick the
    // ready level for the next cycle. Signals read here hold their pre-edge
    // values, so the check never races the block's own updates.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_payload);
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic in_item_t pack_txn(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] smp,
                                          logic [FEATURE_W-1:0] feat);
        in_item_t t;
        t.operation = op;
        t.sample    = smp;
        t.feature   = feat;
        return t;
    endfunction

    // Offer one transaction and return at the edge that accepts it. Valid is
    // left high on return so back-to-back transactions need no second
    // assignment in the same step; an idle gap lowers it first.
    task automatic send_txn(input in_item_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(t);
        if (t.operation != OP_UNUSED) items_sent++;
    endtask

    // Hold the input side until every awaited result is back, then let the
    // block finish any transaction that produces nothing.
    task automatic drain_results();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (sb.awaited_missing.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        sb.report_leftovers();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input bit on);
        drain_results();
        cfg_wr_en       <= 1'b1;
        cfg_wr_data     <= on;
        sb.feature_mode  = on;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // One well-formed round with random content: a few samples, each with a
    // short consecutive run, then queries that mostly hit registered entries.
    // Now and then break the run order or throw in an unused op code.
    task automatic run_round();
        int                   n_keys;
        int                   run;
        int                   n_queries;
        int                   pick;
        int                   k;
        logic [SAMPLE_W-1:0]  key_q [$];
        logic [FEATURE_W-1:0] feat_q [$];
        logic [SAMPLE_W-1:0]  smp;
        logic [FEATURE_W-1:0] feat;
        send_txn(pack_txn(OP_BEGIN_ROUND, SAMPLE_W'($urandom_range(0, NUM_SAMPLES - 1)),
                          FEATURE_W'($urandom_range(0, FEATURE_TOP))));
        n_keys = $urandom_range(1, 6);
        repeat (n_keys) begin
            smp = SAMPLE_W'($urandom_range(0, NUM_SAMPLES - 1));
            run = $urandom_range(1, 4);
            repeat (run) begin
                feat = FEATURE_W'($urandom_range(0, FEATURE_TOP));
                send_txn(pack_txn(OP_REGISTER_DEST, smp, feat));
                key_q.push_back(smp);
                feat_q.push_back(feat);
            end
        end
        // Stray entry for an earlier sample: its run now spans foreign entries.
        if ($urandom_range(99) < 15) begin
            k = $urandom_range(0, key_q.size() - 1);
            feat = FEATURE_W'($urandom_range(0, FEATURE_TOP));
            send_txn(pack_txn(OP_REGISTER_DEST, key_q[k], feat));
            key_q.push_back(key_q[k]);
            feat_q.push_back(feat);
        end
        n_queries = $urandom_range(2, 10);
        repeat (n_queries) begin
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, key_q.size() - 1);
            if (pick < 50)
                send_txn(pack_txn(OP_QUERY_SOURCE, key_q[k], feat_q[k]));
            else if (pick < 70)
                send_txn(pack_txn(OP_QUERY_SOURCE, key_q[k],
                                  FEATURE_W'($urandom_range(0, FEATURE_TOP))));
            else if (pick < 90)
                send_txn(pack_txn(OP_QUERY_SOURCE,
                                  SAMPLE_W'($urandom_range(0, NUM_SAMPLES - 1)),
                                  FEATURE_W'($urandom_range(0, FEATURE_TOP))));
            else
                send_txn(pack_txn(OP_UNUSED, SAMPLE_W'($urandom_range(0, NUM_SAMPLES - 1)),
                                  FEATURE_W'($urandom_range(0, FEATURE_TOP))));
        end
    endtask

    initial begin
        // Sender mostly busy, receiver mostly stalled.
        send_idle_pct = 8;
        recv_idle_pct = 77;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Before the first round the epoch is zero, so every sample reads
        // as stamped; stay in plain mode and do not register anything here.
        send_txn(pack_txn(OP_QUERY_SOURCE, 10'd5, 16'h0000));
        send_txn(pack_txn(OP_QUERY_SOURCE, 10'd1023, 16'hFFFF));
        send_txn(pack_txn(OP_UNUSED, 10'd1023, 16'hFFFF));

        // Plain membership round with extreme samples and features.
        send_txn(pack_txn(OP_BEGIN_ROUND, 10'd0, 16'h0000));
        send_txn(pack_txn(OP_REGISTER_DEST, 10'd0, 16'h0000));
        send_txn(pack_txn(OP_REGISTER_DEST, 10'd0, 16'hFFFF));
        send_txn(pack_txn(OP_REGISTER_DEST, 10'd1023, 16'h1234));
        send_txn(pack_txn(OP_REGISTER_DEST, 10'd512, 16'h8000));
        send_txn(pack_txn(OP_QUERY_SOURCE, 10'd0, 16'h0005));
        send_txn(pack_txn(OP_QUERY_SOURCE, 10'd1023, 16'h0000));
        send_txn(pack_txn(OP_QUERY_SOURCE, 10'd7, 16'h0000));
        send_txn(pack_txn(OP_UNUSED, 10'd0, 16'h0000));
        send_txn(pack_txn(OP_QUERY_SOURCE, 10'd1022, 16'hFFFF));

        // Feature round: sample 3 is split around sample 4, so its scan
        // covers sample 4's entry and misses its own second entry.
        write_mode(1'b1);
        send_txn(pack_txn(OP_BEGIN_ROUND, 10'd0, 16'h0000));
        send_txn(pack_txn(OP_REGISTER_DEST, 10'd3, 16'd10));
        send_txn(pack_txn(OP_REGISTER_DEST, 10'd4, 16'd20));
        send_txn(pack_txn(OP_REGISTER_DEST, 10'd3, 16'd30));
        send_txn(pack_txn(OP_QUERY_SOURCE, 10'd3, 16'd30));
        send_txn(pack_txn(OP_QUERY_SOURCE, 10'd3, 16'd20));
        send_txn(pack_txn(OP_QUERY_SOURCE, 10'd3, 16'd10));
        send_txn(pack_txn(OP_QUERY_SOURCE, 10'd4, 16'd20));
        send_txn(pack_txn(OP_QUERY_SOURCE, 10'd4, 16'hFFFF));
        send_txn(pack_txn(OP_QUERY_SOURCE, 10'd9, 16'd0));
        // Stamp left over from the previous round must not count.
        send_txn(pack_txn(OP_QUERY_SOURCE, 10'd0, 16'h0000));

        // Random rounds in feature mode.
        while (items_sent < 230) run_round();

        // Swap the idle odds and go back to plain mode.
        write_mode(1'b0);
        send_idle_pct = 77;
        recv_idle_pct = 8;
        while (items_sent < 450) run_round();

        // Full speed on both sides, feature mode again.
        write_mode(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (items_sent < 630) run_round();

        drain_results();
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
